// File: rtl/numeric_hash_mersenne61_core_macros.svh
// ---------------------------------------------------------------------------
// Numeric hash core assertion macros
// Short forms for the concurrent checks used by the numeric hash RTL.
// ---------------------------------------------------------------------------
`ifndef NUMERIC_HASH_MERSENNE61_CORE_MACROS_SVH
`define NUMERIC_HASH_MERSENNE61_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define NHM61_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("numeric hash check failed");

// The consequent must hold in the cycle after the antecedent.
`define NHM61_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("numeric hash check failed");

`else

`define NHM61_ASSERT_IMPL(label, clk, rst, ante, cons)
`define NHM61_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/nhm61_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Numeric hash package
// Widths, constants, shared types and the 61-bit rotate for the hash core.
// ---------------------------------------------------------------------------
package nhm61_pkg;

  // Operand and result widths.
  localparam int DATA_W = 64;
  localparam int HASH_BITS = 61;
  localparam int OUT_W = HASH_BITS + 1;
  localparam int RM_W = 6;

  // The Mersenne prime 2^61 - 1 and the infinity hash.
  localparam logic [HASH_BITS-1:0] HASH_MOD = {HASH_BITS{1'b1}};
  localparam logic [HASH_BITS-1:0] HASH_INF = HASH_BITS'(314159);

  // Binary64 field layout.
  localparam int FRAC_W = 52;
  localparam int EXPF_W = 11;
  localparam int MANT_W = FRAC_W + 1;

  // The biased exponent plus this offset equals the true exponent plus
  // 18 * 61, which keeps the value to be reduced mod 61 non-negative.
  localparam int EXP_OFS = 18 * HASH_BITS - 1075;
  localparam int EXQ_W = 12;

  // Division by 61 as a multiply by a scaled reciprocal. The error term
  // stays far below one part in 61 over the exponent range.
  localparam int RECIP_SH = 20;
  localparam int RECIP_K = ((1 << RECIP_SH) + HASH_BITS - 1) / HASH_BITS;
  localparam int RECIP_W = 15;
  localparam int PROD_W = EXQ_W + RECIP_W;
  localparam int QUOT_W = PROD_W - RECIP_SH;

  // Control that travels with a magnitude into the sign stage.
  typedef struct packed {
    logic valid;
    logic neg;
  } nhm61_ctl_t;

  // Rotate a 61-bit value left by r places, r below 61.
  function automatic logic [HASH_BITS-1:0] rotl61(input logic [HASH_BITS-1:0] x,
                                                   input logic [RM_W-1:0] r);
    logic [2*HASH_BITS-1:0] w;
    w = {x, x} << r;
    return w[2*HASH_BITS-1:HASH_BITS];
  endfunction

endpackage

// File: rtl/nhm61_sign_out.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Numeric hash sign stage
// Puts the sign back on a reduced magnitude, replaces -1 by -2, and holds
// the result and its strobe in the output register.
// ---------------------------------------------------------------------------
module nhm61_sign_out (
  input  logic                                   clk,
  input  logic                                   rst,
  input  nhm61_pkg::nhm61_ctl_t                  ctl,
  input  logic [nhm61_pkg::HASH_BITS-1:0]        mag,
  output logic                                   done,
  output logic signed [nhm61_pkg::OUT_W-1:0]     hash_value
);
  import nhm61_pkg::*;

  logic [HASH_BITS-1:0] mag_fix;
  logic [OUT_W-1:0]     hash_next;

  // A negative result of magnitude one is moved to two.
  always_comb begin
    mag_fix = mag;
    if (ctl.neg && (mag == HASH_BITS'(1))) begin
      mag_fix = HASH_BITS'(2);
    end
    if (ctl.neg) begin
      hash_next = OUT_W'(0) - {1'b0, mag_fix};
    end else begin
      hash_next = {1'b0, mag_fix};
    end
  end

  // Output strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      hash_value <= hash_next;
    end
  end

endmodule

// File: rtl/numeric_hash_mersenne61_core.sv
`timescale 1ns / 1ps
`include "numeric_hash_mersenne61_core_macros.svh"
// ---------------------------------------------------------------------------
// Numeric hash modulo 2^61 - 1
// Hashes a signed 64-bit integer or a binary64 bit pattern, chosen by mode,
// into a signed 62-bit value so that equal numbers hash alike.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake       Payload
//  -------   -------------   ----------------------------------
//  input     start / busy    mode, int_value, float_bits
//  result    done            hash_value
//
// One beat enters per clock while busy is low. Its result passes through the
// five register stages (input, decode, fold or exponent remainder, reduce or
// rotate, sign) and then shows on done; the input register loads at the
// accepting edge itself. busy is high only while rst is high; a synchronous
// reset clears every valid bit, so beats in flight are dropped. The receiver
// cannot stall, so the pipeline never holds.
// ---------------------------------------------------------------------------
module numeric_hash_mersenne61_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   mode,
  input  logic signed [nhm61_pkg::DATA_W-1:0]    int_value,
  input  logic [nhm61_pkg::DATA_W-1:0]           float_bits,
  output logic                                   done,
  output logic signed [nhm61_pkg::OUT_W-1:0]     hash_value
);
  import nhm61_pkg::*;

  // Stage 0: input register.
  logic              v0;
  logic              mode0;
  logic [DATA_W-1:0] ival0;
  logic [DATA_W-1:0] fbits0;

  // Stage 1: decode.
  logic              v1;
  logic              mode1;
  logic              neg1;
  logic              nan1;
  logic              inf1;
  logic [DATA_W-1:0] mag1;
  logic [MANT_W-1:0] mant1;
  logic [EXQ_W-1:0]  exq1;
  logic [QUOT_W-1:0] quot1;

  // Stage 2: first fold and exponent remainder.
  logic               v2;
  logic               mode2;
  logic               neg2;
  logic               nan2;
  logic               inf2;
  logic [OUT_W-1:0]   sum2;
  logic [MANT_W-1:0]  mant2;
  logic [RM_W-1:0]    rm2;

  // Stage 3: final reduction or rotation.
  logic               v3;
  logic               mode3;
  logic               neg3;
  logic [HASH_BITS-1:0] mag3;

  // Combinational values between stages.
  logic [EXPF_W-1:0]  ef0;
  logic [EXPF_W-1:0]  efe0;
  logic [EXQ_W-1:0]   exq_next;
  logic [PROD_W-1:0]  prod_next;
  logic [EXQ_W-1:0]   qm_next;
  logic [EXQ_W-1:0]   rm_wide;
  logic [HASH_BITS-1:0] fold_next;
  logic [HASH_BITS-1:0] mag_next;
  logic               neg_next;
  nhm61_ctl_t         ctl3;

  assign busy = rst;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= start;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mode0  <= mode;
      ival0  <= int_value;
      fbits0 <= float_bits;
    end
  end

  // Exponent decode: subnormals share the exponent of the smallest normal.
  always_comb begin
    ef0       = fbits0[DATA_W-2 -: EXPF_W];
    efe0      = (ef0 == '0) ? EXPF_W'(1) : ef0;
    exq_next  = EXQ_W'(efe0) + EXQ_W'(EXP_OFS);
    prod_next = PROD_W'(exq_next) * PROD_W'(RECIP_K);
  end

  // Stage 1: absolute value of the integer, field split of the double.
  always_ff @(posedge clk) begin
    mode1 <= mode0;
    if (mode0) begin
      neg1 <= fbits0[DATA_W-1];
    end else begin
      neg1 <= ival0[DATA_W-1];
    end
    mag1  <= ival0[DATA_W-1] ? (DATA_W'(0) - ival0) : ival0;
    nan1  <= (ef0 == '1) && (fbits0[FRAC_W-1:0] != '0);
    inf1  <= (ef0 == '1) && (fbits0[FRAC_W-1:0] == '0);
    mant1 <= {(ef0 != '0), fbits0[FRAC_W-1:0]};
    exq1  <= exq_next;
    quot1 <= prod_next[PROD_W-1:RECIP_SH];
  end

  // Remainder of the exponent by 61.
  always_comb begin
    qm_next = EXQ_W'(quot1) * EXQ_W'(HASH_BITS);
    rm_wide = exq1 - qm_next;
  end

  // Stage 2: the high bits of the magnitude fold onto the low 61 bits.
  always_ff @(posedge clk) begin
    mode2 <= mode1;
    neg2  <= neg1;
    nan2  <= nan1;
    inf2  <= inf1;
    sum2  <= OUT_W'(mag1[HASH_BITS-1:0]) + OUT_W'(mag1[DATA_W-1:HASH_BITS]);
    mant2 <= mant1;
    rm2   <= rm_wide[RM_W-1:0];
  end

  // Second fold for integers; class select and rotation for doubles.
  always_comb begin
    fold_next = sum2[HASH_BITS-1:0] + HASH_BITS'(sum2[OUT_W-1]);
    if (fold_next == HASH_MOD) begin
      fold_next = '0;
    end
    neg_next = neg2;
    if (!mode2) begin
      mag_next = fold_next;
    end else if (nan2) begin
      mag_next = '0;
      neg_next = 1'b0;
    end else if (inf2) begin
      mag_next = HASH_INF;
    end else begin
      mag_next = rotl61(HASH_BITS'(mant2), rm2);
    end
  end

  // Stage 3 register.
  always_ff @(posedge clk) begin
    mode3 <= mode2;
    neg3  <= neg_next;
    mag3  <= mag_next;
  end

  // Stage 4: sign and output register.
  always_comb begin
    ctl3.valid = v3;
    ctl3.neg   = neg3;
  end

  nhm61_sign_out u_sign (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl3),
    .mag        (mag3),
    .done       (done),
    .hash_value (hash_value)
  );

  // Checks.
  `NHM61_ASSERT_IMPL(a_never_minus_one, clk, rst, done, hash_value != '1)
  `NHM61_ASSERT_IMPL(a_latency, clk, rst, start && !busy, ##5 done)
  `NHM61_ASSERT_IMPL(a_int_reduced, clk, rst, v3 && !mode3, mag3 != HASH_MOD)
  `NHM61_ASSERT_NEXT(a_pos_sign, clk, rst, v3 && !neg3, !hash_value[OUT_W-1])

endmodule

// File: bench/numeric_hash_mersenne61_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Numeric hash core testbench
// Sends integer and binary64 beats through the hash core and checks every
// hash against a typed-in value or the in-bench mod 2^61 - 1 numeric hash
// model. Edge values go first, then randomized beats with idle gaps.
// ---------------------------------------------------------------------------
module numeric_hash_mersenne61_core_tb;

  import nhm61_pkg::*;

  // Operand select codes.
  localparam logic MODE_INT = 1'b0;
  localparam logic MODE_DBL = 1'b1;

  localparam logic [63:0] MERSENNE_P = 64'h1FFF_FFFF_FFFF_FFFF;
  localparam logic [60:0] INF_HASH = 61'd314159;
  localparam int RANDOM_BEATS = 1600;
  localparam int CYCLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_PRINTS = 20;

  // One row of the edge-value table; known marks a typed-in hash.
  typedef struct packed {
    logic                    mode;
    logic [DATA_W-1:0]       ival;
    logic [DATA_W-1:0]       fbits;
    logic                    known;
    logic signed [OUT_W-1:0] hash;
  } edge_row_t;

  localparam int EDGE_N = 25;

  edge_row_t edge_rows [EDGE_N] = '{
    '{MODE_INT, 64'h0000_0000_0000_0000, 64'h0, 1'b1, 62'sd0},
    '{MODE_INT, 64'h0000_0000_0000_0001, 64'h0, 1'b1, 62'sd1},
    '{MODE_INT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, -62'sd2},
    '{MODE_INT, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 1'b1, -62'sd2},
    '{MODE_INT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 62'sd3},
    '{MODE_INT, 64'h8000_0000_0000_0000, 64'h0, 1'b1, -62'sd4},
    '{MODE_INT, 64'h1FFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 62'sd0},
    '{MODE_INT, 64'hE000_0000_0000_0001, 64'h0, 1'b1, 62'sd0},
    '{MODE_INT, 64'h1FFF_FFFF_FFFF_FFFE, 64'h0, 1'b1, 62'sd2305843009213693950},
    '{MODE_INT, 64'hE000_0000_0000_0002, 64'h0, 1'b1, -62'sd2305843009213693950},
    '{MODE_INT, 64'h2000_0000_0000_0000, 64'h0, 1'b1, 62'sd1},
    '{MODE_INT, 64'hE000_0000_0000_0000, 64'h0, 1'b1, -62'sd2},
    '{MODE_INT, 64'h5A5A_1234_0F0F_7777, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 62'sd0},
    '{MODE_DBL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 1'b1, 62'sd0},
    '{MODE_DBL, 64'h0, 64'h8000_0000_0000_0000, 1'b1, 62'sd0},
    '{MODE_DBL, 64'h0, 64'h3FF0_0000_0000_0000, 1'b1, 62'sd1},
    '{MODE_DBL, 64'h0, 64'hBFF0_0000_0000_0000, 1'b1, -62'sd2},
    '{MODE_DBL, 64'h0, 64'h43C0_0000_0000_0000, 1'b1, 62'sd1},
    '{MODE_DBL, 64'h0, 64'h7FF0_0000_0000_0000, 1'b1, 62'sd314159},
    '{MODE_DBL, 64'h0, 64'hFFF0_0000_0000_0000, 1'b1, -62'sd314159},
    '{MODE_DBL, 64'h0, 64'h7FF8_0000_0000_0000, 1'b1, 62'sd0},
    '{MODE_DBL, 64'h0, 64'hFFF0_0000_0000_0001, 1'b1, 62'sd0},
    '{MODE_DBL, 64'h0, 64'h0000_0000_0000_0001, 1'b0, 62'sd0},
    '{MODE_DBL, 64'h0, 64'h800F_FFFF_FFFF_FFFF, 1'b0, 62'sd0},
    '{MODE_DBL, 64'h0, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0, 62'sd0}
  };

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     mode;
  logic signed [DATA_W-1:0] int_value;
  logic [DATA_W-1:0]        float_bits;
  logic                     done;
  logic signed [OUT_W-1:0]  hash_value;

  // Typed-in hash that rides along with the beat being offered.
  logic                     row_known;
  logic signed [OUT_W-1:0]  row_hash;

  logic signed [OUT_W-1:0]  hash_expect_q [$];
  int                       mismatch_cnt = 0;
  int                       int_beats = 0;
  int                       dbl_beats = 0;
  int                       hashes_checked = 0;
  int                       cycle_cnt = 0;

  numeric_hash_mersenne61_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .int_value  (int_value),
    .float_bits (float_bits),
    .done       (done),
    .hash_value (hash_value)
  );

  always #1 clk = ~clk;

  // Put the sign on a reduced magnitude; a hash of -1 is bumped to -2.
  function automatic logic signed [OUT_W-1:0] signed_hash(input logic [60:0] mag,
                                                          input logic neg);
    logic [OUT_W-1:0] w;
    w = {1'b0, mag};
    if (neg) begin
      if (mag == 61'd1) begin
        w = 62'd2;
      end
      w = 62'd0 - w;
    end
    return w;
  endfunction

  // Numeric hash of one operand, integer or binary64, modulo 2^61 - 1.
  function automatic logic signed [OUT_W-1:0] mersenne_hash(input logic m,
                                                            input logic [63:0] iv,
                                                            input logic [63:0] fb);
    logic [63:0] mag;
    logic        neg;
    logic [10:0] ef;
    logic [51:0] frac;
    logic [60:0] mant;
    logic [60:0] rot;
    int          ex;
    int          rm;
    if (m == MODE_INT) begin
      neg = iv[63];
      mag = neg ? (64'd0 - iv) : iv;
      mag = mag % MERSENNE_P;
      return signed_hash(mag[60:0], neg);
    end
    neg = fb[63];
    ef = fb[62:52];
    frac = fb[51:0];
    // All-ones exponent: NaN hashes to zero, infinity to a fixed constant.
    if (ef == 11'h7FF) begin
      if (frac != 52'd0) begin
        return '0;
      end
      return signed_hash(INF_HASH, neg);
    end
    if (ef == 11'd0) begin
      mant = {9'd0, frac};
      ex = -1074;
    end else begin
      mant = {8'd0, 1'b1, frac};
      ex = int'(ef) - 1075;
    end
    // Multiplying by 2^ex is a rotation since 2^61 is 1 mod the prime.
    rm = ex % 61;
    if (rm < 0) begin
      rm += 61;
    end
    rot = (rm == 0) ? mant : ((mant << rm) | (mant >> (61 - rm)));
    return signed_hash(rot, neg);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) begin
      $display("[%0d] mismatch: %s", cycle_cnt, msg);
    end
  endtask

  // Offer one beat and hold it until the core takes it.
  task automatic drive_beat(input logic m, input logic [63:0] iv, input logic [63:0] fb,
                            input logic known, input logic signed [OUT_W-1:0] hash);
    mode <= m;
    int_value <= iv;
    float_bits <= fb;
    row_known <= known;
    row_hash <= hash;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Check each result beat against the oldest expectation, then record any
  // beat accepted at this edge.
  always @(posedge clk) begin : hash_check
    logic signed [OUT_W-1:0] want;
    if (!rst) begin
      if (done) begin
        if (hash_expect_q.size() == 0) begin
          report_mismatch($sformatf("hash %h with no beat waiting", hash_value));
        end else begin
          want = hash_expect_q.pop_front();
          hashes_checked++;
          if (hash_value !== want) begin
            report_mismatch($sformatf("hash_value %h, expected %h", hash_value, want));
          end
        end
      end
      if (start && !busy) begin
        if (mode == MODE_INT) begin
          int_beats++;
        end else begin
          dbl_beats++;
        end
        hash_expect_q.push_back(row_known ? row_hash
                                          : mersenne_hash(mode, int_value, float_bits));
      end
    end
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic        m;
    logic [63:0] iv;
    logic [63:0] fb;
    logic [63:0] k;
    int          sel;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_INT;
    int_value <= '0;
    float_bits <= '0;
    row_known <= 1'b0;
    row_hash <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Edge values: extremes, the prime's neighbors, zeros, infinities, NaN.
    for (int i = 0; i < EDGE_N; i++) begin
      drive_beat(edge_rows[i].mode, edge_rows[i].ival, edge_rows[i].fbits,
                 edge_rows[i].known, edge_rows[i].hash);
    end

    // Randomized beats; the unused operand always carries noise.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      m = ($urandom_range(0, 1) == 1) ? MODE_DBL : MODE_INT;
      iv = {$urandom, $urandom};
      fb = {$urandom, $urandom};
      sel = $urandom_range(0, 9);
      if (m == MODE_INT) begin
        case (sel) inside
          4, 5: begin
            iv = 64'($urandom_range(0, 1000));
          end
          6, 7: begin
            // Near a multiple of the prime, so residues land within 3 of 0 modulo the prime.
            k = 64'($urandom_range(0, 4));
            iv = k * MERSENNE_P + 64'($urandom_range(0, 6)) - 64'd3;
          end
          8: begin
            iv = (($urandom_range(0, 1) == 1) ? 64'h8000_0000_0000_0000
                                               : 64'h7FFF_FFFF_FFFF_FFFF)
                 ^ 64'($urandom_range(0, 7));
          end
          9: begin
            iv = iv >> $urandom_range(0, 63);
          end
          default: begin
          end
        endcase
        if (sel >= 4 && sel <= 9 && $urandom_range(0, 1) == 1) begin
          iv = 64'd0 - iv;
        end
      end else begin
        case (sel) inside
          4: begin
            fb[62:52] = 11'h7FF;
            if ($urandom_range(0, 1) == 1) begin
              fb[51:0] = '0;
            end
          end
          5: begin
            fb[62:52] = 11'd0;
            fb[51:0] = fb[51:0] >> $urandom_range(0, 52);
          end
          6, 7: begin
            fb[62:52] = 11'($urandom_range(1000, 1150));
          end
          8: begin
            fb[62:52] = 11'($urandom_range(1, 2046));
            fb[51:0] = '0;
          end
          9: begin
            fb[51:0] = fb[51:0] >> $urandom_range(20, 52);
          end
          default: begin
          end
        endcase
      end
      drive_beat(m, iv, fb, 1'b0, '0);
      // Random idle cycles, except for a long stretch that runs back to back.
      if (n < 600 || n >= 900) begin
        while ($urandom_range(0, 99) < 27) begin
          start <= 1'b0;
          @(posedge clk);
        end
      end
    end
    start <= 1'b0;

    // Drain the pipeline, then give stray results a chance to show.
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d integer and %0d binary64 beats; %0d hashes checked.",
             int_beats, dbl_beats, hashes_checked);
    $display("Mismatches found: %0d.", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/nhm61_pkg.sv
rtl/nhm61_sign_out.sv
rtl/numeric_hash_mersenne61_core.sv
bench/numeric_hash_mersenne61_core_tb.sv
